// File: design/cisf_pkg.sv
package cisf_pkg;

    // configuration port geometry: three registers on 8-byte strides
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    localparam int PATTERN_BYTES_W  = 64;
    localparam int PATTERN_LENGTH_W = 4;
    localparam int START_POSITION_W = 16;

    // register index, taken from paddr[4:3]
    localparam logic [1:0] REG_PATTERN_BYTES  = 2'd0;
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
    localparam logic [1:0] REG_START_POSITION = 2'd2;

    typedef struct packed {
        logic [PATTERN_BYTES_W-1:0]  pattern_bytes;
        logic [PATTERN_LENGTH_W-1:0] pattern_length;
        logic [START_POSITION_W-1:0] start_position;
    } cfg_t;

    // ascii upper case to lower case, every other byte unchanged
    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// File: design/ci_substring_find.sv
// Case-insensitive substring finder. Text bytes stream in on the s_ side, one
// item per clock (text_char in s_tdata, has_char in s_tuser, last_char in
// s_tlast). Each byte is folded to lower case (ascii letters only) and shifted
// into a window of the newest MAX_PATTERN bytes, which is compared combinationally
// against the folded pattern from the register file. The first match starting
// at or after start_position is kept. The item with tlast gives one result on
// the m_ side: the match index in m_tdata and found in m_tuser, or the text
// length with found low. An empty pattern always gives index 0 with found set.
// Throughput is one item per cycle while the input side does not stall; a final
// item loads the result register at the same edge at which it leaves the input
// register, and the input side only stalls when a final item finds the previous
// result still waiting in that register.
// Bytes past MAX_TEXT are neither counted nor compared. Registers: pattern
// bytes at 0x00 (first char in the low byte), pattern length at 0x08, start
// position at 0x10; write them only while no text is in flight.
module ci_substring_find #(
    parameter  int MAX_PATTERN = 8,
    parameter  int MAX_TEXT    = 65536,
    localparam int PW          = $clog2(MAX_TEXT + 1),
    localparam int OUT_TDATA_W = ((PW + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cisf_pkg::PADDR_W-1:0]     paddr,
    input  logic [cisf_pkg::PDATA_W-1:0]     pwdata,
    output logic [cisf_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    // text input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // text_char
    input  logic                             s_tuser,   // has_char
    input  logic                             s_tlast,   // last_char
    // result output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [OUT_TDATA_W-1:0]           m_tdata,   // match_index, zero padded
    output logic                             m_tuser    // found
);

    // compare width for the start position check
    localparam int CW = (PW > cisf_pkg::START_POSITION_W) ? PW : cisf_pkg::START_POSITION_W;

    cisf_pkg::cfg_t cfg;

    // input register
    logic       pipe_valid_reg;
    logic [7:0] pipe_char_reg;
    logic       pipe_has_reg;
    logic       pipe_last_reg;

    // text state
    logic [MAX_PATTERN-1:0][7:0] win_reg, win_next, win_shift;
    logic [PW-1:0]               pos_reg, pos_next, pos_inc, cand;
    logic                        seen_reg, seen_next;
    logic [PW-1:0]               first_reg, first_next;

    // result register
    logic          out_valid_reg;
    logic [PW-1:0] out_idx_reg, out_idx_next;
    logic          out_found_reg, out_found_next;

    logic take;
    logic len_ok;
    logic win_match;
    logic hit;
    logic advance;
    logic out_load;

    cisf_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cisf_window_cmp #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cmp (
        .win            (win_shift),
        .pattern_bytes  (cfg.pattern_bytes),
        .pattern_length (cfg.pattern_length),
        .match          (win_match)
    );

    // the input register moves on unless a final item meets an unread result
    assign advance  = pipe_valid_reg && (!pipe_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !pipe_valid_reg || advance;
    assign out_load = advance && pipe_last_reg;

    always_comb
    begin
        take = pipe_has_reg && (pos_reg < PW'(MAX_TEXT));

        // window with the new folded byte in front
        win_shift[0] = cisf_pkg::fold_char(pipe_char_reg);
        for (int i = 1; i < MAX_PATTERN; i++)
        begin
            win_shift[i] = win_reg[i-1];
        end

        pos_inc = pos_reg + PW'(1);
        cand    = pos_inc - PW'(cfg.pattern_length);
        len_ok  = (cfg.pattern_length != '0) &&
                  (cfg.pattern_length <= cisf_pkg::PATTERN_LENGTH_W'(MAX_PATTERN));

        // only the first qualifying match counts
        hit = take && !seen_reg && len_ok &&
              (pos_inc >= PW'(cfg.pattern_length)) &&
              (CW'(cand) >= CW'(cfg.start_position)) && win_match;

        win_next   = take ? win_shift : win_reg;
        pos_next   = take ? pos_inc : pos_reg;
        seen_next  = seen_reg || hit;
        first_next = hit ? cand : first_reg;

        // result for a final item
        if (cfg.pattern_length == '0)
        begin
            out_idx_next   = '0;
            out_found_next = 1'b1;
        end
        else if (pos_next == '0)
        begin
            out_idx_next   = '0;
            out_found_next = 1'b0;
        end
        else if (seen_next)
        begin
            out_idx_next   = first_next;
            out_found_next = 1'b1;
        end
        else
        begin
            out_idx_next   = pos_next;
            out_found_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= 1'b0;
            pipe_last_reg  <= 1'b0;
            pipe_has_reg   <= 1'b0;
        end
        else if (s_tready)
        begin
            pipe_valid_reg <= s_tvalid;
            pipe_last_reg  <= s_tlast;
            pipe_has_reg   <= s_tuser;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            pipe_char_reg <= s_tdata;
        end
    end

    // text state, cleared after each final item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            pos_reg   <= '0;
            seen_reg  <= 1'b0;
            first_reg <= '0;
        end
        else if (advance)
        begin
            if (pipe_last_reg)
            begin
                win_reg   <= '0;
                pos_reg   <= '0;
                seen_reg  <= 1'b0;
                first_reg <= '0;
            end
            else
            begin
                win_reg   <= win_next;
                pos_reg   <= pos_next;
                seen_reg  <= seen_next;
                first_reg <= first_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_idx_reg   <= out_idx_next;
            out_found_reg <= out_found_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_idx_reg);
    assign m_tuser  = out_found_reg;

    // a kept match always starts before the current text position
    assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> (first_reg < pos_reg))
        else $error("match start not below text position");

    // the byte counter never runs past the text limit
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(MAX_TEXT))
        else $error("text position beyond limit");

    // a result only follows a final item leaving the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pipe_valid_reg && pipe_last_reg))
        else $error("result without a final item");

    // the match index is only held together with the seen flag
    assert property (@(posedge clk) disable iff (!rst_n)
        !seen_reg |-> (first_reg == '0))
        else $error("stale match index");

endmodule

// File: design/cisf_apb_regs.sv
module cisf_apb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cisf_pkg::PADDR_W-1:0]  paddr,
    input  logic [cisf_pkg::PDATA_W-1:0]  pwdata,
    output logic [cisf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output cisf_pkg::cfg_t                cfg
);

    cisf_pkg::cfg_t cfg_reg;
    logic [1:0]     reg_index;
    logic           wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:3];
    assign wr_en     = psel && penable && pwrite && pready;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                cisf_pkg::REG_PATTERN_BYTES:
                    cfg_reg.pattern_bytes <= pwdata;
                cisf_pkg::REG_PATTERN_LENGTH:
                    cfg_reg.pattern_length <= pwdata[cisf_pkg::PATTERN_LENGTH_W-1:0];
                cisf_pkg::REG_START_POSITION:
                    cfg_reg.start_position <= pwdata[cisf_pkg::START_POSITION_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            cisf_pkg::REG_PATTERN_BYTES:
                prdata = cfg_reg.pattern_bytes;
            cisf_pkg::REG_PATTERN_LENGTH:
                prdata = cisf_pkg::PDATA_W'(cfg_reg.pattern_length);
            cisf_pkg::REG_START_POSITION:
                prdata = cisf_pkg::PDATA_W'(cfg_reg.start_position);
            default:
                prdata = '0;
        endcase
    end

endmodule

// File: design/cisf_window_cmp.sv
module cisf_window_cmp #(
    parameter int MAX_PATTERN = 8
) (
    input  logic [MAX_PATTERN-1:0][7:0]                win,
    input  logic [cisf_pkg::PATTERN_BYTES_W-1:0]       pattern_bytes,
    input  logic [cisf_pkg::PATTERN_LENGTH_W-1:0]      pattern_length,
    output logic                                       match
);

    // hit_len[l]: the newest l window bytes equal the first l pattern bytes
    logic [MAX_PATTERN:1] hit_len;

    always_comb
    begin
        for (int l = 1; l <= MAX_PATTERN; l++)
        begin
            hit_len[l] = 1'b1;
            for (int k = 0; k < l; k++)
            begin
                if (win[l-1-k] != cisf_pkg::fold_char(pattern_bytes[8*k +: 8]))
                begin
                    hit_len[l] = 1'b0;
                end
            end
        end
        match = 1'b0;
        for (int l = 1; l <= MAX_PATTERN; l++)
        begin
            if (pattern_length == cisf_pkg::PATTERN_LENGTH_W'(l))
            begin
                match = hit_len[l];
            end
        end
    end

endmodule

// File: bench/substring_check_pkg.sv
package substring_check_pkg;

    import cisf_pkg::*;

    // running copy of the finder: text state, register copy and pending results
    class substring_scoreboard;

        logic [63:0] pattern;
        logic [3:0]  pattern_len;
        logic [15:0] start_at;

        logic [7:0]  recent [8];    // folded bytes, entry 0 newest
        logic [16:0] taken;
        bit          hit;
        logic [16:0] hit_at;

        logic [16:0] want_index [$];
        bit          want_found [$];

        int failures;
        int results;

        function new();
            pattern     = '0;
            pattern_len = '0;
            start_at    = '0;
            failures    = 0;
            results     = 0;
            clear_text();
        endfunction

        function void clear_text();
            foreach (recent[i])
                recent[i] = 8'h00;
            taken  = '0;
            hit    = 1'b0;
            hit_at = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] value);
            case (idx)
                REG_PATTERN_BYTES:  pattern     = value;
                REG_PATTERN_LENGTH: pattern_len = value[3:0];
                REG_START_POSITION: start_at    = value[15:0];
                default: ;
            endcase
        endfunction

        static function logic [7:0] to_lower(logic [7:0] c);
            return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
        endfunction

        // pattern char k lines up with window entry n-1-k
        function bit window_hit(int n);
            for (int k = 0; k < n; k++)
            begin
                if (recent[n - 1 - k] != to_lower(pattern[8*k +: 8]))
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_item(logic [7:0] c, bit has, bit last);
            int          n;
            logic [16:0] cand;
            logic [16:0] idx;
            bit          fnd;
            n = pattern_len;
            if (has && taken < 17'h10000)
            begin
                for (int i = 7; i > 0; i--)
                    recent[i] = recent[i - 1];
                recent[0] = to_lower(c);
                taken     = taken + 17'd1;
                if (!hit && n != 0 && n <= 8 && taken >= n)
                begin
                    cand = taken - 17'(n);
                    if (cand >= start_at && window_hit(n))
                    begin
                        hit    = 1'b1;
                        hit_at = cand;
                    end
                end
            end
            if (!last)
                return;
            if (n == 0)
            begin
                idx = '0;
                fnd = 1'b1;
            end
            else if (taken == 0)
            begin
                idx = '0;
                fnd = 1'b0;
            end
            else if (hit)
            begin
                idx = hit_at;
                fnd = 1'b1;
            end
            else
            begin
                idx = taken;
                fnd = 1'b0;
            end
            want_index = {want_index, idx};
            want_found = {want_found, fnd};
            clear_text();
        endfunction

        function void check_result(logic [23:0] data, logic fnd, time stamp);
            logic [16:0] exp_index;
            bit          exp_found;
            if (want_index.size() == 0)
            begin
                failures++;
                $display("%0d ns: result with nothing pending, index %0d found %0b",
                         stamp, data, fnd);
                return;
            end
            exp_index = want_index.pop_front();
            exp_found = want_found.pop_front();
            results++;
            if (data !== {7'b0, exp_index})
            begin
                failures++;
                $display("%0d ns: match_index expected %0d, got %0d",
                         stamp, exp_index, data);
            end
            if (fnd !== exp_found)
            begin
                failures++;
                $display("%0d ns: found expected %0b, got %0b", stamp, exp_found, fnd);
            end
        endfunction

        function int pending();
            return want_index.size();
        endfunction

    endclass

endpackage

// File: bench/ci_substring_find_test.sv
module ci_substring_find_test;

    timeunit 1ns;
    timeprecision 1ps;

    import cisf_pkg::*;
    import substring_check_pkg::*;

    typedef logic [7:0] text_q_t [$];

    // quiet cycles (nothing moving on either side) before the run is abandoned
    localparam int WATCHDOG_LIMIT = 5000;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [PADDR_W-1:0]          paddr;
    logic [PDATA_W-1:0]          pwdata;
    logic [PDATA_W-1:0]          prdata;
    logic                        pready;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [7:0]                  s_tdata;   // text_char
    logic                        s_tuser;   // has_char
    logic                        s_tlast;   // last_char
    logic                        m_tvalid;
    logic                        m_tready;
    logic [23:0]                 m_tdata;   // match_index (17 bits), zero padded
    logic                        m_tuser;   // found

    substring_scoreboard sb = new();

    // idling knobs, percent of cycles
    int src_idle_pct;
    int sink_stall_pct;
    int noise_pct;
    // long receiver hold-off, counted down by the receiver process
    int hold_off;

    int text_items;
    int input_stalls;
    int settings_used;
    int quiet_cycles;

    // mirror of the current register values, used to shape the random texts
    logic [63:0] cur_pat;
    logic [3:0]  cur_len;

    ci_substring_find dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // monitor: every accepted item feeds the predictor, every result gets checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sb.note_item(s_tdata, s_tuser, s_tlast);
                if (s_tuser || s_tlast)
                    text_items++;
            end
            if (s_tvalid && !s_tready)
                input_stalls++;
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, $time);
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                m_tready = 1'b0;
                hold_off--;
            end
            else
                m_tready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // watchdog: any accepted item on either side restarts the count
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0d ns: nothing moved for %0d cycles, %0d results still pending",
                 $time, WATCHDOG_LIMIT, sb.pending());
        $display("Test completed with failures");
        $finish;
    end

    // random upper/lower case on ascii letters, anything else untouched
    function automatic logic [7:0] case_mix(logic [7:0] c);
        logic [7:0] low;
        low = c | 8'h20;
        if (low >= 8'h61 && low <= 8'h7A && $urandom_range(1) == 1)
            return c ^ 8'h20;
        return c;
    endfunction

    // entered and left at a falling edge; valid stays up across back-to-back items
    task automatic send_item(input logic [7:0] c, input bit has, input bit last);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            s_tdata  = 8'($urandom_range(255));
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = c;
        s_tuser  = has;
        s_tlast  = last;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // one whole text; end_by_marker closes it with a has_char=0 item
    task automatic send_text(input text_q_t t, input bit end_by_marker);
        for (int i = 0; i < t.size(); i++)
        begin
            if (noise_pct != 0 && $urandom_range(99) < noise_pct)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(t[i], 1'b1, (i == t.size() - 1) && !end_by_marker);
        end
        if (t.size() == 0 || end_by_marker)
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic send_str(input string s);
        text_q_t t;
        for (int i = 0; i < s.len(); i++)
            t = {t, s[i]};
        send_text(t, 1'b0);
    endtask

    // drain: every expected result in, then a wait for ignored items still in flight
    task automatic wait_quiet();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // apb write: setup cycle, access cycle, register taken when pready is seen
    task automatic reg_write(input logic [1:0] idx, input logic [63:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(input logic [63:0] pat, input logic [3:0] len,
                             input logic [15:0] from);
        wait_quiet();
        reg_write(REG_PATTERN_BYTES, pat);
        reg_write(REG_PATTERN_LENGTH, {60'b0, len});
        reg_write(REG_START_POSITION, {48'b0, from});
        cur_pat = pat;
        cur_len = len;
        settings_used++;
    endtask

    // mostly short letter patterns so texts built from them hit and near-miss
    task automatic pick_setting();
        logic [63:0] pat;
        logic [3:0]  len;
        logic [15:0] from;
        int          r;
        r = $urandom_range(99);
        for (int k = 0; k < 8; k++)
        begin
            if (r < 70)
                pat[8*k +: 8] = case_mix(8'(8'h61 + $urandom_range(2)));
            else
                // bytes on either side of the folding ranges
                pat[8*k +: 8] = 8'(64'h40415A5B60617A7B >> (8 * $urandom_range(7)));
        end
        if (r >= 85 && r < 93)
            pat = {$urandom, $urandom};
        else if (r >= 93 && r < 97)
            pat = '1;
        else if (r >= 97)
            pat = '0;
        r = $urandom_range(99);
        if (r < 5)
            len = 4'd0;
        else if (r < 15)
            len = 4'($urandom_range(15, 9));
        else if (r < 30)
            len = 4'd8;
        else
            len = 4'($urandom_range(7, 1));
        r = $urandom_range(99);
        if (r < 60)
            from = '0;
        else if (r < 90)
            from = 16'($urandom_range(10));
        else if (r < 95)
            from = 16'hFFFF;
        else
            from = 16'($urandom_range(65535));
        configure(pat, len, from);
    endtask

    // filler drawn from the pattern's own chars, often with a full copy planted
    function automatic text_q_t make_text();
        text_q_t t;
        int      n;
        int      at;
        int      span;
        n    = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(14);
        span = (cur_len >= 1 && cur_len <= 8) ? cur_len : 8;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 70)
                t = {t, case_mix(cur_pat[8 * $urandom_range(span - 1) +: 8])};
            else
                t = {t, 8'($urandom_range(255))};
        end
        if (cur_len >= 1 && cur_len <= 8 && n >= cur_len && $urandom_range(99) < 60)
        begin
            at = $urandom_range(n - cur_len);
            for (int j = 0; j < cur_len; j++)
                t[at + j] = case_mix(cur_pat[8*j +: 8]);
        end
        return t;
    endfunction

    task automatic run_phase(input int src_pct, input int sink_pct, input int goal);
        int      mark;
        text_q_t t;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        noise_pct      = 5;
        mark           = text_items;
        while (text_items - mark < goal)
        begin
            pick_setting();
            repeat ($urandom_range(8, 3))
            begin
                t = make_text();
                send_text(t, $urandom_range(9) == 0);
            end
        end
        noise_pct = 0;
    endtask

    initial
    begin
        text_q_t t;
        int      stalls_before;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        s_tlast        = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        noise_pct      = 0;
        hold_off       = 0;
        text_items     = 0;
        input_stalls   = 0;
        settings_used  = 0;
        cur_pat        = '0;
        cur_len        = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed part, no idling ---

        // registers still at reset: empty pattern gives index 0, found
        send_str("Ab");

        // "aB", folded on both sides
        configure(64'h4261, 4'd2, 16'd0);
        send_str("xAb");
        // empty text
        send_text(t, 1'b0);
        // an ignored item must not disturb the next text
        send_item(8'hA5, 1'b0, 1'b0);
        send_str("ab");
        // pattern longer than the text
        send_str("a");

        // start beyond the end of the text
        configure(64'h4261, 4'd2, 16'd5);
        send_str("abab");

        // length above what the window can hold never matches
        configure(64'h6161616161616161, 4'd15, 16'd0);
        send_str("aaaaaaaaa");

        // extremes of text_char and pattern_bytes; 0xff compared as is
        configure('1, 4'd1, 16'd0);
        t = {t, 8'h00};
        t = {t, 8'hFF};
        send_text(t, 1'b0);

        // '`' must not match '@' (no folding outside A..Z)
        configure(64'h60, 4'd1, 16'd0);
        t = {};
        t = {t, 8'h40};
        t = {t, 8'h60};
        send_text(t, 1'b0);

        // --- texts past the length limit ---

        // 'q' at the highest start index; 'q's past the limit are dropped
        configure(64'h71, 4'd1, 16'hFFFF);
        for (int i = 0; i < 65540; i++)
            send_item((i == 65535) ? 8'h51 : ((i > 65536) ? 8'h71 : 8'h62),
                      1'b1, i == 65539);
        // no match can start at 65535 with two chars, so the length 65536 comes back
        configure(64'h6262, 4'd2, 16'hFFFF);
        for (int i = 0; i < 65538; i++)
            send_item(8'h62, 1'b1, i == 65537);

        // --- random part, one phase per idling mode ---
        run_phase(0, 0, 250);
        run_phase(71, 0, 250);
        run_phase(0, 71, 250);
        run_phase(17, 17, 250);

        // --- back pressure: receiver held off while short texts keep coming ---
        pick_setting();
        wait_quiet();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        stalls_before  = input_stalls;
        hold_off       = 400;
        repeat (60)
        begin
            t = {};
            repeat ($urandom_range(2))
                t = {t, case_mix(cur_pat[7:0])};
            send_text(t, 1'b0);
        end

        // --- wind down ---
        wait_quiet();
        repeat (10) @(negedge clk);

        $display("%0d text items sent, %0d results checked over %0d register settings",
                 text_items, sb.results, settings_used);
        $display("input stalled %0d cycles, %0d of them under the receiver hold-off",
                 input_stalls, input_stalls - stalls_before);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
